// ===== rtl/crm_pkg.sv =====
`default_nettype none
// crm_pkg: shared types and constants of the curved range mapper.
// No dependencies; used by every rtl file of the block and by the bench.
package crm_pkg;

  typedef enum logic [2:0] {
    MODE_CURVE = 3'b000,
    MODE_ZERO  = 3'b001,
    MODE_ONE   = 3'b010,
    MODE_INV   = 3'b011,
    MODE_EMPTY = 3'b100
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } tag_t;

  localparam logic [2:0] REG_SOURCE_MIN   = 3'd0;
  localparam logic [2:0] REG_SOURCE_MAX   = 3'd1;
  localparam logic [2:0] REG_TARGET_MIN   = 3'd2;
  localparam logic [2:0] REG_TARGET_MAX   = 3'd3;
  localparam logic [2:0] REG_CURVE_TENTHS = 3'd4;

  localparam int QB = 30;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_MASK    = 64'd1073741823;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] LOG2_10_Q30 = 64'd3566893132;
  localparam int CURVE_LIMIT  = 100;
  localparam int CURVE_COUNT  = 2 * CURVE_LIMIT + 1;
  localparam int P24_W        = 28;
  localparam int TAYLOR_TERMS = 11;

  // elaboration-time 2^(+/-mag), Q.30
  function automatic logic [63:0] exp2_q30_const(input logic [63:0] mag, input logic neg);
    logic [63:0] ip;
    logic [63:0] f;
    logic [63:0] rf;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    ip = mag >> QB;
    rf = mag & Q30_MASK;
    f  = rf;
    if (neg) begin
      if (rf == 64'd0) begin
        f = 64'd0;
      end else begin
        ip = ip + 64'd1;
        f  = Q30_ONE - rf;
      end
    end
    x    = (f * LN2_Q30) >> QB;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * x) >> QB) / 64'(k);
      sum  = sum + term;
    end
    if (!neg) begin
      return sum << ip;
    end
    if (ip >= 64'd62) begin
      return 64'd0;
    end
    return sum >> ip;
  endfunction

  // exponent p = 10^(-c/100), Q.24
  function automatic logic [63:0] curve_p24(input int c);
    logic [63:0] mag;
    mag = (64'(c < 0 ? -c : c) * LOG2_10_Q30 + 64'd50) / 64'd100;
    return exp2_q30_const(mag, c > 0) >> 6;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/curved_range_mapper_top.sv =====
`default_nettype none
// curved_range_mapper_top: clamp, normalize, power curve and target rescale.
// Depends on crm_pkg, crm_neglog2 and crm_exp2.
//
//  channel  ports                                   handshake
//  input    start, busy, in_value                   start && !busy
//  result   out_valid, out_mapped_value,            one-cycle strobe
//           out_range_error
//  config   cfg_valid, cfg_ready, cfg_index,        cfg_valid && cfg_ready
//           cfg_data
//
// One item per cycle. The pipe holds the divider (one quotient bit a stage),
// 30 log squaring stages and three stages per exp series term. busy stays
// low, cfg_ready high. Reset is synchronous, active low, clears the valid
// bits and sets the config registers to their defaults; data registers are
// not reset. The receiver cannot stall, so nothing in the pipe ever waits.
module curved_range_mapper_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  output logic signed [15:0] out_mapped_value,
  output logic               out_range_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NL_W      = $clog2(FRACTION_BITS + 1) + 30;
  localparam int Y_W       = NL_W + 4;
  localparam int N_W       = 17 + FRACTION_BITS;
  localparam int DIV_STEPS = FRACTION_BITS + 1;
  localparam int SPLIT     = 18;
  localparam int P24_W     = crm_pkg::P24_W;
  localparam int PH_W      = NL_W - SPLIT + P24_W;
  localparam int PL_W      = SPLIT + P24_W;
  localparam int PROD_W    = NL_W + P24_W;
  localparam int SC_W      = FRACTION_BITS + 17;
  localparam logic [FRACTION_BITS:0] V_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [32:0] PW_HALF = 33'(1) << (29 - FRACTION_BITS);
  localparam logic signed [8:0] C_LIM = 9'(crm_pkg::CURVE_LIMIT);

  // configuration
  logic signed [15:0] src_min_r;
  logic signed [15:0] src_max_r;
  logic signed [15:0] tgt_min_r;
  logic signed [15:0] tgt_max_r;
  logic signed [7:0]  curve_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_min_r <= 16'sd0;
      src_max_r <= 16'sd32767;
      tgt_min_r <= 16'sd0;
      tgt_max_r <= 16'sd32767;
      curve_r   <= 8'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crm_pkg::REG_SOURCE_MIN:   src_min_r <= cfg_data;
        crm_pkg::REG_SOURCE_MAX:   src_max_r <= cfg_data;
        crm_pkg::REG_TARGET_MIN:   tgt_min_r <= cfg_data;
        crm_pkg::REG_TARGET_MAX:   tgt_max_r <= cfg_data;
        crm_pkg::REG_CURVE_TENTHS: curve_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // values derived from configuration, refreshed every cycle
  logic [15:0]      src_range_r;
  logic [15:0]      tgt_range_r;
  logic             tgt_down_r;
  logic [P24_W-1:0] p24_r;
  logic [P24_W-1:0] p24_tab [crm_pkg::CURVE_COUNT];
  logic signed [8:0] c_ext;
  logic [7:0]       c_idx;
  logic             tgt_down_nxt;

  for (genvar gi = 0; gi < crm_pkg::CURVE_COUNT; gi++) begin : g_p24
    localparam logic [63:0] PV = crm_pkg::curve_p24(gi - crm_pkg::CURVE_LIMIT);
    assign p24_tab[gi] = PV[P24_W-1:0];
  end

  assign c_ext        = {curve_r[7], curve_r};
  assign tgt_down_nxt = !(tgt_max_r > tgt_min_r);

  always_comb begin
    priority if (c_ext > C_LIM) begin
      c_idx = 8'(2 * crm_pkg::CURVE_LIMIT);
    end else if (c_ext < -C_LIM) begin
      c_idx = 8'd0;
    end else begin
      c_idx = 8'(c_ext + C_LIM);
    end
  end

  always_ff @(posedge clk) begin
    src_range_r <= 16'(src_max_r - src_min_r);
    tgt_down_r  <= tgt_down_nxt;
    tgt_range_r <= tgt_down_nxt ? 16'(tgt_min_r - tgt_max_r) : 16'(tgt_max_r - tgt_min_r);
    p24_r       <= p24_tab[c_idx];
  end

  // stage 0: clamp and offset
  logic               in_accept;
  logic signed [15:0] x_clamp;
  crm_pkg::tag_t      s0_tag_nxt;
  crm_pkg::tag_t      s0_tag_r;
  logic [15:0]        s0_d_r;

  assign in_accept = start && !busy;

  always_comb begin
    priority if (in_value < src_min_r) begin
      x_clamp = src_min_r;
    end else if (in_value > src_max_r) begin
      x_clamp = src_max_r;
    end else begin
      x_clamp = in_value;
    end
    s0_tag_nxt.valid = in_accept;
    priority if (src_min_r > src_max_r) begin
      s0_tag_nxt.mode = crm_pkg::MODE_INV;
    end else if (src_min_r == src_max_r) begin
      s0_tag_nxt.mode = crm_pkg::MODE_EMPTY;
    end else begin
      s0_tag_nxt.mode = crm_pkg::MODE_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_tag_r.valid <= 1'b0;
    end else begin
      s0_tag_r <= s0_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_d_r <= 16'(x_clamp - src_min_r);
  end

  // stage 1: rounded dividend
  crm_pkg::tag_t  s1_tag_r;
  logic [N_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
    end else begin
      s1_tag_r <= s0_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= N_W'({s0_d_r, {FRACTION_BITS{1'b0}}}) + N_W'(src_range_r[15:1]);
  end

  // restoring divider, one quotient bit a stage
  crm_pkg::tag_t            div_tag_r [DIV_STEPS];
  logic [FRACTION_BITS:0]   div_q_r   [DIV_STEPS];
  logic [15:0]              div_rem_r [DIV_STEPS-1];
  logic [FRACTION_BITS:0]   div_low_r [DIV_STEPS-1];

  for (genvar gd = 0; gd < DIV_STEPS; gd++) begin : g_div
    crm_pkg::tag_t          tag_in;
    logic [15:0]            rem_in;
    logic [FRACTION_BITS:0] low_in;
    logic [FRACTION_BITS:0] q_in;
    logic [16:0]            rem2;
    logic                   ge;

    if (gd == 0) begin : g_first
      assign tag_in = s1_tag_r;
      assign rem_in = n_r[N_W-1:FRACTION_BITS+1];
      assign low_in = n_r[FRACTION_BITS:0];
      assign q_in   = '0;
    end else begin : g_next
      assign tag_in = div_tag_r[gd-1];
      assign rem_in = div_rem_r[gd-1];
      assign low_in = div_low_r[gd-1];
      assign q_in   = div_q_r[gd-1];
    end

    assign rem2 = {rem_in, low_in[FRACTION_BITS-gd]};
    assign ge   = rem2 >= {1'b0, src_range_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_tag_r[gd].valid <= 1'b0;
      end else begin
        div_tag_r[gd] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      div_q_r[gd] <= {q_in[FRACTION_BITS-1:0], ge};
    end

    if (gd < DIV_STEPS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        div_rem_r[gd] <= ge ? 16'(rem2 - {1'b0, src_range_r}) : rem2[15:0];
        div_low_r[gd] <= low_in;
      end
    end
  end

  // classify normalized value, then log
  crm_pkg::tag_t          lg_tag_in;
  logic [FRACTION_BITS:0] u_q;
  crm_pkg::tag_t          lg_tag;
  logic [NL_W-1:0]        lg_nl;

  assign u_q = div_q_r[DIV_STEPS-1];

  always_comb begin
    lg_tag_in = div_tag_r[DIV_STEPS-1];
    if (lg_tag_in.mode == crm_pkg::MODE_CURVE) begin
      priority if (u_q == '0) begin
        lg_tag_in.mode = crm_pkg::MODE_ZERO;
      end else if (u_q[FRACTION_BITS]) begin
        lg_tag_in.mode = crm_pkg::MODE_ONE;
      end else begin
        lg_tag_in.mode = crm_pkg::MODE_CURVE;
      end
    end
  end

  crm_neglog2 #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_neglog2 (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (lg_tag_in),
    .u_i   (u_q[FRACTION_BITS-1:0]),
    .tag_o (lg_tag),
    .nl_o  (lg_nl)
  );

  // y = (nl * p24) >> 24 in two partial products
  crm_pkg::tag_t     mul_tag_r;
  logic [PH_W-1:0]   ph_r;
  logic [PL_W-1:0]   pl_r;
  crm_pkg::tag_t     y_tag_r;
  logic [Y_W-1:0]    y_r;
  logic [PROD_W-1:0] prod_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_tag_r.valid <= 1'b0;
      y_tag_r.valid   <= 1'b0;
    end else begin
      mul_tag_r <= lg_tag;
      y_tag_r   <= mul_tag_r;
    end
  end

  assign prod_full = {ph_r, {SPLIT{1'b0}}} + PROD_W'(pl_r);

  always_ff @(posedge clk) begin
    ph_r <= PH_W'(lg_nl[NL_W-1:SPLIT]) * PH_W'(p24_r);
    pl_r <= PL_W'(lg_nl[SPLIT-1:0]) * PL_W'(p24_r);
    y_r  <= prod_full[PROD_W-1:24];
  end

  crm_pkg::tag_t ex_tag;
  logic [31:0]   ex_pw;

  crm_exp2 #(
    .Y_W(Y_W)
  ) u_exp2 (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (y_tag_r),
    .y_i   (y_r),
    .tag_o (ex_tag),
    .pw_o  (ex_pw)
  );

  // power value in Q1.F
  crm_pkg::tag_t            v_tag_r;
  logic [FRACTION_BITS:0]   v_r;
  logic [FRACTION_BITS:0]   v_nxt;
  logic [32:0]              pw_round;
  logic [FRACTION_BITS+2:0] v_t;

  assign pw_round = {1'b0, ex_pw} + PW_HALF;
  assign v_t      = pw_round[32:30-FRACTION_BITS];

  always_comb begin
    unique case (ex_tag.mode)
      crm_pkg::MODE_CURVE: begin
        v_nxt = (v_t > (FRACTION_BITS+3)'(V_ONE)) ? V_ONE : v_t[FRACTION_BITS:0];
      end
      crm_pkg::MODE_ONE: v_nxt = V_ONE;
      default:           v_nxt = '0;
    endcase
  end

  // target scale
  crm_pkg::tag_t   sc_tag_r;
  logic [16:0]     sc_r;
  logic [SC_W-1:0] sc_prod;

  assign sc_prod = SC_W'(v_r) * SC_W'(tgt_range_r) + SC_W'(V_ONE >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_tag_r.valid  <= 1'b0;
      sc_tag_r.valid <= 1'b0;
    end else begin
      v_tag_r  <= ex_tag;
      sc_tag_r <= v_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v_nxt;
    sc_r <= sc_prod[SC_W-1:FRACTION_BITS];
  end

  // result register
  logic               out_valid_r;
  logic signed [15:0] mapped_r;
  logic               err_r;
  logic signed [15:0] mapped_nxt;
  logic               err_nxt;

  always_comb begin
    err_nxt = 1'b0;
    unique case (sc_tag_r.mode)
      crm_pkg::MODE_INV: mapped_nxt = 16'sd0;
      crm_pkg::MODE_EMPTY: begin
        mapped_nxt = tgt_min_r;
        err_nxt    = 1'b1;
      end
      default: begin
        mapped_nxt = tgt_down_r ? 16'(tgt_min_r - sc_r[15:0]) : 16'(tgt_min_r + sc_r[15:0]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sc_tag_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    mapped_r <= mapped_nxt;
    err_r    <= err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_value = mapped_r;
  assign out_range_error  = err_r;

endmodule
`default_nettype wire

// ===== rtl/crm_neglog2.sv =====
`default_nettype none
// crm_neglog2: pipelined -log2(u / 2^F) in Q.30, one squaring per stage.
// Depends on crm_pkg (tag_t).
module crm_neglog2 #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  crm_pkg::tag_t                         tag_i,
  input  logic [FRACTION_BITS-1:0]              u_i,
  output crm_pkg::tag_t                         tag_o,
  output logic [$clog2(FRACTION_BITS+1)+29:0]   nl_o
);

  localparam int NL_W  = $clog2(FRACTION_BITS + 1) + 30;
  localparam int IW    = NL_W - 30;
  localparam int BW    = $clog2(FRACTION_BITS);
  localparam int STEPS = 30;
  localparam logic [IW-1:0] FB = IW'(FRACTION_BITS);

  crm_pkg::tag_t tag_r  [STEPS+1];
  logic [BW-1:0] lead_r [STEPS+1];
  logic [29:0]   frac_r [STEPS+1];
  logic [30:0]   m_r    [STEPS];

  logic [BW-1:0] lead_nxt;
  logic [30:0]   m0_nxt;

  always_comb begin
    lead_nxt = '0;
    for (int i = 0; i < FRACTION_BITS; i++) begin
      if (u_i[i]) lead_nxt = BW'(i);
    end
    m0_nxt = 31'({{(31-FRACTION_BITS){1'b0}}, u_i} << (5'd30 - 5'(lead_nxt)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0].valid <= 1'b0;
    end else begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    lead_r[0] <= lead_nxt;
    frac_r[0] <= '0;
    m_r[0]    <= m0_nxt;
  end

  for (genvar gs = 1; gs <= STEPS; gs++) begin : g_sq
    logic [61:0] sq;
    logic        hit;
    assign sq  = 62'(m_r[gs-1]) * 62'(m_r[gs-1]);
    assign hit = sq[61];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[gs].valid <= 1'b0;
      end else begin
        tag_r[gs] <= tag_r[gs-1];
      end
    end

    always_ff @(posedge clk) begin
      lead_r[gs] <= lead_r[gs-1];
      frac_r[gs] <= {frac_r[gs-1][28:0], hit};
    end

    if (gs < STEPS) begin : g_m
      always_ff @(posedge clk) begin
        m_r[gs] <= hit ? sq[61:31] : sq[60:30];
      end
    end
  end

  crm_pkg::tag_t   tag_out_r;
  logic [NL_W-1:0] nl_r;
  logic [NL_W-1:0] nl_nxt;
  logic [IW-1:0]   int_part;

  assign int_part = FB - IW'(lead_r[STEPS]);
  assign nl_nxt   = {int_part, 30'd0} - {{IW{1'b0}}, frac_r[STEPS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_out_r.valid <= 1'b0;
    end else begin
      tag_out_r <= tag_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    nl_r <= nl_nxt;
  end

  assign tag_o = tag_out_r;
  assign nl_o  = nl_r;

endmodule
`default_nettype wire

// ===== rtl/crm_exp2.sv =====
`default_nettype none
// crm_exp2: pipelined 2^(-y) for y in Q.30, Taylor series of exp(f*ln2).
// Depends on crm_pkg (tag_t, constants).
module crm_exp2 #(
  parameter int Y_W = 39
) (
  input  logic          clk,
  input  logic          rst_n,
  input  crm_pkg::tag_t tag_i,
  input  logic [Y_W-1:0] y_i,
  output crm_pkg::tag_t tag_o,
  output logic [31:0]   pw_o
);

  localparam int K   = crm_pkg::TAYLOR_TERMS;
  localparam int S_W = Y_W - 29;
  localparam logic [29:0] LN2 = 30'(crm_pkg::LN2_Q30);

  typedef struct packed {
    crm_pkg::tag_t tag;
    logic          zero;
    logic [4:0]    sh;
    logic [29:0]   x;
    logic [31:0]   sum;
  } side_t;

  // split into shift and fraction
  crm_pkg::tag_t e0_tag_r;
  logic [29:0]   e0_f_r;
  logic [4:0]    e0_sh_r;
  logic          e0_zero_r;
  logic [29:0]   rf;
  logic [S_W-1:0] s_nxt;

  assign rf    = y_i[29:0];
  assign s_nxt = S_W'(y_i[Y_W-1:30]) + S_W'(rf != 30'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_tag_r.valid <= 1'b0;
    end else begin
      e0_tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    e0_f_r    <= 30'd0 - rf;
    e0_sh_r   <= s_nxt[4:0];
    e0_zero_r <= s_nxt > S_W'(30);
  end

  // x = f * ln2
  side_t       e1_r;
  side_t       e1_nxt;
  logic [59:0] xprod;

  assign xprod = 60'(e0_f_r) * 60'(LN2);

  always_comb begin
    e1_nxt.tag  = e0_tag_r;
    e1_nxt.zero = e0_zero_r;
    e1_nxt.sh   = e0_sh_r;
    e1_nxt.x    = xprod[59:30];
    e1_nxt.sum  = 32'(crm_pkg::Q30_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r.tag.valid <= 1'b0;
    end else begin
      e1_r <= e1_nxt;
    end
  end

  side_t       side_a_r [K];
  side_t       side_b_r [K];
  side_t       side_c_r [K];
  logic [29:0] a_r      [K];
  logic [29:0] ab_r     [K];
  logic [29:0] q0_r     [K];
  logic [30:0] term_r   [K-1];

  for (genvar gj = 0; gj < K; gj++) begin : g_term
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / (gj + 1));
    localparam logic [4:0]  KV    = 5'(gj + 1);

    side_t       side_in;
    side_t       side_c_nxt;
    logic [30:0] term_in;
    logic [60:0] tprod;
    logic [62:0] rprod;
    logic [34:0] rem;
    logic [30:0] term_nxt;

    if (gj == 0) begin : g_first
      assign side_in = e1_r;
      assign term_in = 31'(crm_pkg::Q30_ONE);
    end else begin : g_next
      assign side_in = side_c_r[gj-1];
      assign term_in = term_r[gj-1];
    end

    assign tprod = 61'(term_in) * 61'(side_in.x);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_a_r[gj].tag.valid <= 1'b0;
      end else begin
        side_a_r[gj] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      a_r[gj] <= tprod[59:30];
    end

    // divide by k: reciprocal estimate, then one correction
    assign rprod = 63'(a_r[gj]) * 63'(RECIP);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_b_r[gj].tag.valid <= 1'b0;
      end else begin
        side_b_r[gj] <= side_a_r[gj];
      end
    end

    always_ff @(posedge clk) begin
      ab_r[gj] <= a_r[gj];
      q0_r[gj] <= rprod[61:32];
    end

    assign rem      = 35'(ab_r[gj]) - 35'(q0_r[gj]) * 35'(KV);
    assign term_nxt = (rem >= 35'(KV)) ? 31'(q0_r[gj]) + 31'd1 : 31'(q0_r[gj]);

    always_comb begin
      side_c_nxt     = side_b_r[gj];
      side_c_nxt.sum = side_b_r[gj].sum + 32'(term_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_c_r[gj].tag.valid <= 1'b0;
      end else begin
        side_c_r[gj] <= side_c_nxt;
      end
    end

    if (gj < K - 1) begin : g_keep
      always_ff @(posedge clk) begin
        term_r[gj] <= term_nxt;
      end
    end
  end

  crm_pkg::tag_t tag_out_r;
  logic [31:0]   pw_r;
  logic [31:0]   pw_nxt;

  assign pw_nxt = side_c_r[K-1].zero ? 32'd0 : (side_c_r[K-1].sum >> side_c_r[K-1].sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_out_r.valid <= 1'b0;
    end else begin
      tag_out_r <= side_c_r[K-1].tag;
    end
  end

  always_ff @(posedge clk) begin
    pw_r <= pw_nxt;
  end

  assign tag_o = tag_out_r;
  assign pw_o  = pw_r;

endmodule
`default_nettype wire

// ===== test/tb_curved_range_mapper_top.sv =====
`timescale 1ns / 1ps
// tb_curved_range_mapper_top: self-checking bench for curved_range_mapper_top.
// Bit-exact power-curve predictor, queue-fed driver, strobe monitor.
// Depends on crm_pkg and the rtl of the block.
module tb_curved_range_mapper_top;

  localparam int FB = 16;
  localparam int DRAIN_CYCLES = FB + 120;
  localparam logic [2:0] REG_UNUSED  = 3'd5;
  localparam logic [2:0] REG_SPARE   = 3'd7;

  typedef struct packed {
    logic signed [15:0] mapped;
    logic               range_err;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_value = '0;
  logic out_valid;
  logic signed [15:0] out_mapped_value;
  logic out_range_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic signed [15:0] src_min_q, src_max_q, tgt_min_q, tgt_max_q;
  logic signed [7:0]  curve_q;

  logic signed [15:0] pending_values[$];
  map_result_t        expected_maps[$];
  int                 gap_left = 0;
  int                 error_count = 0;

  curved_range_mapper_top #(.FRACTION_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value(in_value),
    .out_valid(out_valid), .out_mapped_value(out_mapped_value),
    .out_range_error(out_range_error), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned pow2_q30(input longint e);
    longint unsigned f, x, sum, term, m, q, rf;
    longint ip;
    if (e >= 0) begin
      ip = e >>> 30;
      f = longint'(e) & crm_pkg::Q30_MASK;
    end else begin
      m = -e;
      q = m >> 30;
      rf = m & crm_pkg::Q30_MASK;
      if (rf == 0) begin
        ip = -longint'(q);
        f = 0;
      end else begin
        ip = -longint'(q) - 1;
        f = crm_pkg::Q30_ONE - rf;
      end
    end
    x = (f * crm_pkg::LN2_Q30) >> 30;
    sum = crm_pkg::Q30_ONE;
    term = crm_pkg::Q30_ONE;
    for (int k = 1; k <= 20 && term != 0; k++) begin
      term = ((term * x) >> 30) / k;
      sum += term;
    end
    if (ip >= 0) begin
      if (ip > 31) ip = 31;
      return sum << ip;
    end
    if (-ip >= 62) return 0;
    return sum >> (-ip);
  endfunction

  function automatic longint unsigned neg_log2_q30(input longint unsigned u);
    int b;
    longint unsigned m, frac;
    b = 0;
    frac = 0;
    while ((u >> (b + 1)) != 0) b++;
    m = u << (30 - b);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (crm_pkg::Q30_ONE << 1)) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return longint'(FB - b) * crm_pkg::Q30_ONE - frac;
  endfunction

  function automatic map_result_t curve_map(input logic signed [15:0] value);
    map_result_t res;
    longint smin, smax, tmin, tmax, c, x, e, outv;
    longint unsigned one, r, d, u, v, mag, p24, y, pw, span, scaled;
    smin = src_min_q; smax = src_max_q; tmin = tgt_min_q; tmax = tgt_max_q;
    c = curve_q;
    x = value;
    one = 64'd1 << FB;
    res.range_err = 1'b0;
    if (smin > smax) begin
      res.mapped = '0;
      return res;
    end
    if (smin == smax) begin
      res.mapped = tgt_min_q;
      res.range_err = 1'b1;
      return res;
    end
    if (x < smin) x = smin;
    if (x > smax) x = smax;
    if (c > crm_pkg::CURVE_LIMIT) c = crm_pkg::CURVE_LIMIT;
    if (c < -crm_pkg::CURVE_LIMIT) c = -crm_pkg::CURVE_LIMIT;
    r = smax - smin;
    d = x - smin;
    u = ((d << FB) + r / 2) / r;
    if (u == 0) v = 0;
    else if (u >= one) v = one;
    else begin
      mag = ((c < 0 ? -c : c) * crm_pkg::LOG2_10_Q30 + 50) / 100;
      e = (c > 0) ? -longint'(mag) : longint'(mag);
      p24 = pow2_q30(e) >> 6;
      y = (neg_log2_q30(u) * p24) >> 24;
      pw = pow2_q30(-longint'(y));
      v = (pw + (64'd1 << (29 - FB))) >> (30 - FB);
      if (v > one) v = one;
    end
    if (tmax > tmin) begin
      span = tmax - tmin;
      scaled = (v * span + (one >> 1)) >> FB;
      outv = tmin + longint'(scaled);
    end else begin
      span = tmin - tmax;
      scaled = (v * span + (one >> 1)) >> FB;
      outv = tmin - longint'(scaled);
    end
    res.mapped = outv[15:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // register shadow
  always @(posedge clk) begin
    if (!rst_n) begin
      src_min_q <= 16'sd0;
      src_max_q <= 16'sd32767;
      tgt_min_q <= 16'sd0;
      tgt_max_q <= 16'sd32767;
      curve_q   <= 8'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crm_pkg::REG_SOURCE_MIN:   src_min_q <= cfg_data;
        crm_pkg::REG_SOURCE_MAX:   src_max_q <= cfg_data;
        crm_pkg::REG_TARGET_MIN:   tgt_min_q <= cfg_data;
        crm_pkg::REG_TARGET_MAX:   tgt_max_q <= cfg_data;
        crm_pkg::REG_CURVE_TENTHS: curve_q   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_maps.push_back(curve_map(in_value));
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_values.size() > 0) begin
        start <= 1'b1;
        in_value <= pending_values.pop_front();
        case ($urandom_range(0, 19))
          0:       gap_left <= $urandom_range(10, 40);
          1, 2, 3: gap_left <= $urandom_range(1, 3);
          default: gap_left <= 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_valid) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("unexpected item mapped_value", out_mapped_value, 0);
      end else begin
        want = expected_maps.pop_front();
        if (out_mapped_value !== want.mapped)
          report_mismatch("mapped_value", out_mapped_value, want.mapped);
        if (out_range_error !== want.range_err)
          report_mismatch("range_error", out_range_error, want.range_err);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_map(input int smin, input int smax, input int tmin, input int tmax,
                         input int curve);
    write_reg(crm_pkg::REG_SOURCE_MIN, smin[15:0]);
    write_reg(crm_pkg::REG_SOURCE_MAX, smax[15:0]);
    write_reg(crm_pkg::REG_TARGET_MIN, tmin[15:0]);
    write_reg(crm_pkg::REG_TARGET_MAX, tmax[15:0]);
    write_reg(crm_pkg::REG_CURVE_TENTHS, curve[15:0]);
  endtask

  task automatic drain;
    while (pending_values.size() > 0 || expected_maps.size() > 0 || start) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int count, input int smin, input int smax);
    int lo, hi;
    for (int i = 0; i < count; i++) begin
      lo = smin < smax ? smin : smax;
      hi = smin < smax ? smax : smin;
      case ($urandom_range(0, 9))
        0: pending_values.push_back(16'($urandom()));
        1: pending_values.push_back(16'(lo));
        2: pending_values.push_back(16'(hi));
        3: pending_values.push_back(16'(lo + 1));
        default: pending_values.push_back(16'($urandom_range(hi - lo, 0) + lo));
      endcase
    end
  endtask

  initial begin
    int a, b, t0, t1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes and corners
    pending_values.push_back(16'sh8000);
    pending_values.push_back(16'sh7fff);
    pending_values.push_back(16'sd0);
    pending_values.push_back(16'sd1);
    pending_values.push_back(16'sd2);
    pending_values.push_back(-16'sd1);
    pending_values.push_back(16'sd16384);
    pending_values.push_back(16'sd32766);
    drain();

    set_map(-32768, 32767, 32767, -32768, 127);
    pending_values.push_back(16'sh8000);
    pending_values.push_back(16'sh8001);
    pending_values.push_back(16'sd0);
    pending_values.push_back(16'sh7fff);
    drain();
    set_map(-32768, 32767, -32768, 32767, -128);
    pending_values.push_back(16'sh8001);
    pending_values.push_back(16'sd0);
    pending_values.push_back(16'sh7ffe);
    drain();
    set_map(100, -100, 5, 9, 100);
    pending_values.push_back(16'sd0);
    pending_values.push_back(16'sh7fff);
    drain();
    set_map(-7, -7, -1234, 9, -100);
    pending_values.push_back(16'sd0);
    pending_values.push_back(-16'sd7);
    drain();
    set_map(0, 1000, 777, 777, 50);
    write_reg(REG_UNUSED, 16'hffff);
    write_reg(REG_SPARE, 16'h1234);
    pending_values.push_back(16'sd500);
    pending_values.push_back(16'sd1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      a = $urandom_range(65535, 0) - 32768;
      b = $urandom_range(65535, 0) - 32768;
      if ($urandom_range(0, 9) < 8) begin
        if (a > b) begin t0 = a; a = b; b = t0; end
        if (a == b) b = a + 1 > 32767 ? a : a + 1;
        if ($urandom_range(0, 2) == 0 && a + 64 < 32767) b = a + $urandom_range(64, 1);
      end else if ($urandom_range(0, 1) == 0) begin
        b = a;
      end
      t0 = $urandom_range(65535, 0) - 32768;
      t1 = $urandom_range(65535, 0) - 32768;
      set_map(a, b, t0, t1, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(200) - 100);
      queue_random(50, a, b);
      drain();
    end

    if (error_count == 0) begin
      $display("curved_range_mapper_top test passed");
    end else begin
      $display("curved_range_mapper_top test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("curved_range_mapper_top test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/crm_pkg.sv
rtl/crm_neglog2.sv
rtl/crm_exp2.sv
rtl/curved_range_mapper_top.sv
test/tb_curved_range_mapper_top.sv
